FILE: sv/hsv2rgb_pkg.sv
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// shared widths, scale constants and types for the hsv to rgb converter
// ----------------------------------------------------------------------------
`default_nettype none

package hsv2rgb_pkg;

    // field widths
    localparam int HUE_W   = 9;
    localparam int SCALE_W = 8;
    localparam int CHAN_W  = 8;

    // scale constants
    localparam int FULL_SCALE = 200;
    localparam int SECTOR_DEG = 60;
    localparam int HUE_WRAP   = 360;
    localparam int CHAN_MAX   = 255;
    localparam int FRAC_W     = 6;

    // every channel is a * x / DIV_D with a = 255*v and x in 0..FULL_X
    localparam int FULL_X = SECTOR_DEG * FULL_SCALE;
    localparam int X_W    = 14;
    localparam int A_W    = 16;
    localparam int N_W    = 30;
    localparam int DIV_D  = FULL_X * FULL_SCALE;
    localparam int D_W    = 22;

    // reciprocal of DIV_D scaled by 2**RECIP_K, error below one count
    localparam int RECIP_K   = 30;
    localparam int RECIP_M   = (1 << RECIP_K) / DIV_D;
    localparam int RECIP_M_W = 9;
    localparam int PROD_W    = N_W + RECIP_M_W;

    typedef enum logic [2:0] {
        SECTOR_RY = 3'd0,
        SECTOR_YG = 3'd1,
        SECTOR_GC = 3'd2,
        SECTOR_CB = 3'd3,
        SECTOR_BM = 3'd4,
        SECTOR_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic             valid;
        logic [A_W-1:0]   a;
        logic [X_W-1:0]   x_r;
        logic [X_W-1:0]   x_g;
        logic [X_W-1:0]   x_b;
    } t_prep_out;

endpackage

`default_nettype wire

FILE: sv/hsv_to_rgb_converter_top.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_top
// hsv colour (hue in degrees, saturation and value on 0..200) to 8-bit rgb
// ----------------------------------------------------------------------------
//  channel | direction | signals                                  | beat
//  input   | in        | start, busy, i_hue, i_saturation,        | start & !busy
//          |           | i_brightness                             |
//  result  | out       | o_valid, o_red, o_green, o_blue          | o_valid
//
//  one beat per clock; busy is always low
//  the pipeline has 3 front stages, then per channel multiply, reciprocal
//  multiply, back-multiply and correction
//  synchronous reset clears the valid pipeline only
//  results show for one cycle; the receiver cannot stall
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb_converter_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]    i_hue,
    input  wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_saturation,
    input  wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_brightness,
    output logic                                  o_valid,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_red,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_green,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]        o_blue
);

    hsv2rgb_pkg::t_prep_out prep;
    logic                   accept;
    logic                   v_r, v_g, v_b;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    hsv2rgb_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .o_prep       (prep)
    );

    hsv2rgb_scale u_scale_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep.valid),
        .i_a     (prep.a),
        .i_x     (prep.x_r),
        .o_valid (v_r),
        .o_chan  (o_red)
    );

    hsv2rgb_scale u_scale_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep.valid),
        .i_a     (prep.a),
        .i_x     (prep.x_g),
        .o_valid (v_g),
        .o_chan  (o_green)
    );

    hsv2rgb_scale u_scale_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prep.valid),
        .i_a     (prep.a),
        .i_x     (prep.x_b),
        .o_valid (v_b),
        .o_chan  (o_blue)
    );

    assign o_valid = v_r & v_g & v_b;

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_prep.sv
// ----------------------------------------------------------------------------
// hsv2rgb_prep
// front stages: hue sector split, clamping, and per-channel numerator terms
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_prep (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [hsv2rgb_pkg::HUE_W-1:0]    i_hue,
    input  wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_saturation,
    input  wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_brightness,
    output hsv2rgb_pkg::t_prep_out                o_prep
);

    localparam int HW = hsv2rgb_pkg::HUE_W;
    localparam int SW = hsv2rgb_pkg::SCALE_W;
    localparam int FW = hsv2rgb_pkg::FRAC_W;
    localparam int XW = hsv2rgb_pkg::X_W;
    localparam int AW = hsv2rgb_pkg::A_W;
    localparam int DEG = hsv2rgb_pkg::SECTOR_DEG;

    // stage 1
    logic                  r_v1;
    hsv2rgb_pkg::t_sector  r_sector1, n_sector1;
    logic [FW-1:0]         r_frac1, n_frac1;
    logic [SW-1:0]         r_sat1, n_sat1;
    logic [SW-1:0]         r_val1, n_val1;
    logic [HW-1:0]         hue_w;

    // stage 2
    logic                  r_v2;
    hsv2rgb_pkg::t_sector  r_sector2;
    logic [AW-1:0]         r_a2;
    logic [XW-1:0]         r_sf2, r_st2, r_px2;

    // stage 3
    logic                  r_v3;
    logic [AW-1:0]         r_a3;
    logic [XW-1:0]         r_xr3, r_xg3, r_xb3;
    logic [XW-1:0]         n_xr3, n_xg3, n_xb3;
    logic [XW-1:0]         xv, xp, xq, xt;

    always_comb begin
        hue_w = (i_hue >= HW'(hsv2rgb_pkg::HUE_WRAP)) ? '0 : i_hue;
        n_sat1 = (i_saturation > SW'(hsv2rgb_pkg::FULL_SCALE)) ?
                 SW'(hsv2rgb_pkg::FULL_SCALE) : i_saturation;
        n_val1 = (i_brightness > SW'(hsv2rgb_pkg::FULL_SCALE)) ?
                 SW'(hsv2rgb_pkg::FULL_SCALE) : i_brightness;
        if (hue_w >= HW'(5 * DEG)) begin
            n_sector1 = hsv2rgb_pkg::SECTOR_MR;
            n_frac1   = FW'(hue_w - HW'(5 * DEG));
        end else if (hue_w >= HW'(4 * DEG)) begin
            n_sector1 = hsv2rgb_pkg::SECTOR_BM;
            n_frac1   = FW'(hue_w - HW'(4 * DEG));
        end else if (hue_w >= HW'(3 * DEG)) begin
            n_sector1 = hsv2rgb_pkg::SECTOR_CB;
            n_frac1   = FW'(hue_w - HW'(3 * DEG));
        end else if (hue_w >= HW'(2 * DEG)) begin
            n_sector1 = hsv2rgb_pkg::SECTOR_GC;
            n_frac1   = FW'(hue_w - HW'(2 * DEG));
        end else if (hue_w >= HW'(DEG)) begin
            n_sector1 = hsv2rgb_pkg::SECTOR_YG;
            n_frac1   = FW'(hue_w - HW'(DEG));
        end else begin
            n_sector1 = hsv2rgb_pkg::SECTOR_RY;
            n_frac1   = FW'(hue_w);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sector1 <= n_sector1;
        r_frac1   <= n_frac1;
        r_sat1    <= n_sat1;
        r_val1    <= n_val1;
        // a = 255*v, sf and st are the saturation-weighted hue offsets
        r_sector2 <= r_sector1;
        r_a2      <= {r_val1, 8'b0} - AW'(r_val1);
        r_sf2     <= XW'(r_sat1) * XW'(r_frac1);
        r_st2     <= XW'(r_sat1) * XW'(FW'(DEG) - r_frac1);
        r_px2     <= XW'(DEG) * XW'(SW'(hsv2rgb_pkg::FULL_SCALE) - r_sat1);
        r_a3      <= r_a2;
        r_xr3     <= n_xr3;
        r_xg3     <= n_xg3;
        r_xb3     <= n_xb3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // all four terms share the denominator 255*12000*200/255
    always_comb begin
        xv = XW'(hsv2rgb_pkg::FULL_X);
        xp = r_px2;
        xq = XW'(hsv2rgb_pkg::FULL_X) - r_sf2;
        xt = XW'(hsv2rgb_pkg::FULL_X) - r_st2;
        case (r_sector2)
            hsv2rgb_pkg::SECTOR_RY: begin
                n_xr3 = xv; n_xg3 = xt; n_xb3 = xp;
            end
            hsv2rgb_pkg::SECTOR_YG: begin
                n_xr3 = xq; n_xg3 = xv; n_xb3 = xp;
            end
            hsv2rgb_pkg::SECTOR_GC: begin
                n_xr3 = xp; n_xg3 = xv; n_xb3 = xt;
            end
            hsv2rgb_pkg::SECTOR_CB: begin
                n_xr3 = xp; n_xg3 = xq; n_xb3 = xv;
            end
            hsv2rgb_pkg::SECTOR_BM: begin
                n_xr3 = xt; n_xg3 = xp; n_xb3 = xv;
            end
            default: begin
                n_xr3 = xv; n_xg3 = xp; n_xb3 = xq;
            end
        endcase
    end

    always_comb begin
        o_prep.valid = r_v3;
        o_prep.a     = r_a3;
        o_prep.x_r   = r_xr3;
        o_prep.x_g   = r_xg3;
        o_prep.x_b   = r_xb3;
    end

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_scale.sv
// ----------------------------------------------------------------------------
// hsv2rgb_scale
// one channel lane: a*x then truncating divide by a constant via reciprocal
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_scale (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire logic [hsv2rgb_pkg::A_W-1:0]     i_a,
    input  wire logic [hsv2rgb_pkg::X_W-1:0]     i_x,
    output logic                                 o_valid,
    output logic [hsv2rgb_pkg::CHAN_W-1:0]       o_chan
);

    localparam int NW = hsv2rgb_pkg::N_W;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int CW = hsv2rgb_pkg::CHAN_W;
    localparam int K  = hsv2rgb_pkg::RECIP_K;

    logic [NW-1:0] r_n4;
    logic [NW-1:0] r_n5;
    logic [CW-1:0] r_q5;
    logic [NW-1:0] r_n6;
    logic [CW-1:0] r_q6;
    logic [NW-1:0] r_qd6;
    logic [CW-1:0] r_chan7;
    logic [PW-1:0] prod;
    logic [NW-1:0] rem;
    logic [3:0]    r_v;

    always_comb begin
        prod = PW'(r_n4) * PW'(hsv2rgb_pkg::RECIP_M);
        rem  = r_n6 - r_qd6;
    end

    always_ff @(posedge i_clk) begin
        r_n4  <= NW'(i_a) * NW'(i_x);
        // estimate is exact or one short
        r_n5  <= r_n4;
        r_q5  <= prod[K+CW-1:K];
        r_n6  <= r_n5;
        r_q6  <= r_q5;
        r_qd6 <= NW'(r_q5) * NW'(hsv2rgb_pkg::DIV_D);
        r_chan7 <= (rem >= NW'(hsv2rgb_pkg::DIV_D)) ? r_q6 + CW'(1) : r_q6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign o_valid = r_v[3];
    assign o_chan  = r_chan7;

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_checker.sv
// ----------------------------------------------------------------------------
// hsv2rgb_checker
// port-level checks on latency and on grey and black colours
// ----------------------------------------------------------------------------
`default_nettype none

module hsv2rgb_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic [hsv2rgb_pkg::HUE_W-1:0]    i_hue,
    input wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_saturation,
    input wire logic [hsv2rgb_pkg::SCALE_W-1:0]  i_brightness,
    input wire logic                             o_valid,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   o_red,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   o_green,
    input wire logic [hsv2rgb_pkg::CHAN_W-1:0]   o_blue
);

    // every accepted beat comes out on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("result missing seven cycles after accepted beat");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, 7) && !$past(busy, 7)))
        else $error("result without matching input beat");

    // zero saturation gives grey
    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation == '0) |->
        ##7 (o_red == o_green && o_green == o_blue))
        else $error("zero saturation not grey");

    // zero value gives black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_brightness == '0) |->
        ##7 (o_red == '0 && o_green == '0 && o_blue == '0))
        else $error("zero value not black");

endmodule

bind hsv_to_rgb_converter_top hsv2rgb_checker u_checker (.*);

`default_nettype wire
